// ===== rtl/dttf_pkg.sv =====
// ----------------------------------------------------------------------------
// dttf_pkg
// Shared types, constants and arithmetic helpers of the decimal text to
// fixed point parser.
// ----------------------------------------------------------------------------
package dttf_pkg;

  localparam int CHAR_W              = 8;
  localparam int VALUE_W             = 53;
  localparam int DIGIT_W             = 4;
  localparam int FRAC_CNT_W          = 3;
  localparam int IDX_W               = 2;
  localparam int ERR_W               = 2;
  localparam int FLAG_W              = 3;
  localparam int FRACTION_DIGITS_DEF = 4;
  localparam int QUEUE_DEPTH_DEF     = 2;

  localparam logic [VALUE_W-1:0] VALUE_MAX = {VALUE_W{1'b1}};

  // Character codes
  localparam logic [CHAR_W-1:0] ASCII_NUL   = 8'd0;
  localparam logic [CHAR_W-1:0] ASCII_TAB   = 8'd9;
  localparam logic [CHAR_W-1:0] ASCII_BLANK = 8'd32;
  localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'd45;
  localparam logic [CHAR_W-1:0] ASCII_POINT = 8'd46;
  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'd48;
  localparam logic [CHAR_W-1:0] ASCII_NINE  = 8'd57;

  // Field flag bit positions
  localparam int FLAG_BAD   = 0;
  localparam int FLAG_MINUS = 1;
  localparam int FLAG_OVF   = 2;

  typedef enum logic [2:0] {
    CLS_BLANK,
    CLS_NUL,
    CLS_DIGIT,
    CLS_POINT,
    CLS_MINUS,
    CLS_OTHER
  } cls_e;

  // Classified character travelling from front to back
  typedef struct packed {
    cls_e               cls;
    logic [DIGIT_W-1:0] digit;
  } tok_t;

  // Finished field travelling through the scaling stages
  typedef struct packed {
    logic [VALUE_W-1:0]    value;
    logic [FRAC_CNT_W-1:0] pad;
    logic                  found;
    logic                  bad;
    logic                  minus;
    logic                  ovf;
    logic [ERR_W-1:0]      sticky;
  } item_t;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               ovf;
  } mul_res_t;

  // x*10+d, saturated at the field maximum
  function automatic mul_res_t mul10_add(logic [VALUE_W-1:0] x, logic [DIGIT_W-1:0] d);
    logic [VALUE_W+3:0] r;
    mul_res_t           m;
    r = ({4'b0, x} << 3) + ({4'b0, x} << 1) + {{VALUE_W{1'b0}}, d};
    m.ovf   = |r[VALUE_W+3:VALUE_W];
    m.value = m.ovf ? VALUE_MAX : r[VALUE_W-1:0];
    return m;
  endfunction

endpackage

// ===== rtl/dttf_class.sv =====
// ----------------------------------------------------------------------------
// dttf_class
// Front end: classifies each accepted character into a token for the queue.
// ----------------------------------------------------------------------------
module dttf_class import dttf_pkg::*; (
  input  logic              push_i,
  input  logic              q_full_i,
  input  logic [CHAR_W-1:0] ch_i,
  output logic              q_wr_o,
  output tok_t              tok_o
);

  // Accept a transaction whenever the queue has room
  assign q_wr_o = push_i && !q_full_i;

  // Classify the character
  always_comb begin
    tok_o.digit = ch_i[DIGIT_W-1:0];
    if (ch_i == ASCII_BLANK || ch_i == ASCII_TAB) begin
      tok_o.cls = CLS_BLANK;
    end else if (ch_i == ASCII_NUL) begin
      tok_o.cls = CLS_NUL;
    end else if (ch_i >= ASCII_ZERO && ch_i <= ASCII_NINE) begin
      tok_o.cls = CLS_DIGIT;
    end else if (ch_i == ASCII_POINT) begin
      tok_o.cls = CLS_POINT;
    end else if (ch_i == ASCII_MINUS) begin
      tok_o.cls = CLS_MINUS;
    end else begin
      tok_o.cls = CLS_OTHER;
    end
  end

endmodule

// ===== rtl/dttf_queue.sv =====
// ----------------------------------------------------------------------------
// dttf_queue
// Short token queue decoupling the front end from the back end.
// ----------------------------------------------------------------------------
module dttf_queue import dttf_pkg::*; #(
  parameter int Depth = QUEUE_DEPTH_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_i,
  input  tok_t wr_tok_i,
  output logic full_o,
  input  logic rd_i,
  output logic valid_o,
  output tok_t rd_tok_o
);

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);

  tok_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o   = (cnt_q == CntW'(Depth));
  assign valid_o  = (cnt_q != '0);
  assign rd_tok_o = mem_q[rd_ptr_q];

  // Advance pointers and fill level
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr_i) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (rd_i) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    if (wr_i && !rd_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!wr_i && rd_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store the token
  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wr_ptr_q] <= wr_tok_i;
    end
  end

endmodule

// ===== rtl/dttf_accum.sv =====
// ----------------------------------------------------------------------------
// dttf_accum
// Back end: walks the token stream, accumulates the magnitude and closes
// each field into an item for the scaling stages.
// ----------------------------------------------------------------------------
module dttf_accum import dttf_pkg::*; #(
  parameter int FractionDigits = FRACTION_DIGITS_DEF
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  tok_valid_i,
  input  tok_t  tok_i,
  output logic  tok_pop_o,
  input  logic  res_ready_i,
  output logic  res_valid_o,
  output item_t res_o
);

  localparam logic [FRAC_CNT_W-1:0] FracMax = FRAC_CNT_W'(FractionDigits);

  logic [VALUE_W-1:0]    accum_q, accum_d;
  logic                  in_field_q, in_field_d;
  logic                  digit_seen_q, digit_seen_d;
  logic                  point_seen_q, point_seen_d;
  logic [FRAC_CNT_W-1:0] frac_count_q, frac_count_d;
  logic [IDX_W-1:0]      char_index_q, char_index_d;
  logic                  first_minus_q, first_minus_d;
  logic [FLAG_W-1:0]     flags_q, flags_d;
  logic [ERR_W-1:0]      err_q, err_d;

  logic     is_blank, is_nul, finish, skip;
  logic     take_digit;
  mul_res_t step;
  logic [ERR_W-1:0] err_new;

  assign tok_pop_o = tok_valid_i && res_ready_i;
  assign is_blank  = (tok_i.cls == CLS_BLANK);
  assign is_nul    = (tok_i.cls == CLS_NUL);
  assign finish    = is_nul || (in_field_q && is_blank);
  assign skip      = !in_field_q && is_blank;
  assign step      = mul10_add(accum_q, tok_i.digit);
  assign take_digit = !point_seen_q || (frac_count_q < FracMax);
  assign err_new   = err_q | flags_q[FLAG_MINUS:FLAG_BAD];

  // Close the field
  assign res_valid_o = tok_pop_o && finish;
  always_comb begin
    res_o.value  = digit_seen_q ? accum_q : '0;
    res_o.pad    = digit_seen_q ? FracMax - frac_count_q : '0;
    res_o.found  = digit_seen_q;
    res_o.bad    = flags_q[FLAG_BAD];
    res_o.minus  = flags_q[FLAG_MINUS];
    res_o.ovf    = flags_q[FLAG_OVF];
    res_o.sticky = err_new;
  end

  // Update the field state for one token
  always_comb begin
    accum_d       = accum_q;
    in_field_d    = in_field_q;
    digit_seen_d  = digit_seen_q;
    point_seen_d  = point_seen_q;
    frac_count_d  = frac_count_q;
    char_index_d  = char_index_q;
    first_minus_d = first_minus_q;
    flags_d       = flags_q;
    err_d         = err_q;
    if (tok_pop_o) begin
      if (finish) begin
        accum_d       = '0;
        in_field_d    = 1'b0;
        digit_seen_d  = 1'b0;
        point_seen_d  = 1'b0;
        frac_count_d  = '0;
        char_index_d  = '0;
        first_minus_d = 1'b0;
        flags_d       = '0;
        err_d         = err_new;
      end else if (!skip) begin
        in_field_d = 1'b1;
        if (tok_i.cls == CLS_DIGIT) begin
          if (char_index_q == IDX_W'(1) && first_minus_q) begin
            flags_d[FLAG_MINUS] = 1'b1;
          end
          digit_seen_d = 1'b1;
          if (take_digit) begin
            accum_d = step.value;
            if (step.ovf) begin
              flags_d[FLAG_OVF] = 1'b1;
            end
            if (point_seen_q) begin
              frac_count_d = frac_count_q + 1'b1;
            end
          end
        end else if (tok_i.cls == CLS_POINT && !point_seen_q) begin
          point_seen_d = 1'b1;
        end else begin
          if (char_index_q == '0 && tok_i.cls == CLS_MINUS) begin
            first_minus_d = 1'b1;
          end
          flags_d[FLAG_BAD] = 1'b1;
        end
        if (char_index_q != '1) begin
          char_index_d = char_index_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accum_q       <= '0;
      in_field_q    <= 1'b0;
      digit_seen_q  <= 1'b0;
      point_seen_q  <= 1'b0;
      frac_count_q  <= '0;
      char_index_q  <= '0;
      first_minus_q <= 1'b0;
      flags_q       <= '0;
      err_q         <= '0;
    end else begin
      accum_q       <= accum_d;
      in_field_q    <= in_field_d;
      digit_seen_q  <= digit_seen_d;
      point_seen_q  <= point_seen_d;
      frac_count_q  <= frac_count_d;
      char_index_q  <= char_index_d;
      first_minus_q <= first_minus_d;
      flags_q       <= flags_d;
      err_q         <= err_d;
    end
  end

endmodule

// ===== rtl/dttf_scale.sv =====
// ----------------------------------------------------------------------------
// dttf_scale
// Scaling pipeline: one conditional times-ten step between neighbouring stages pads
// the value to the full fraction width. The last stage is the result register.
// ----------------------------------------------------------------------------
module dttf_scale import dttf_pkg::*; #(
  parameter int FractionDigits = FRACTION_DIGITS_DEF
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  input  item_t in_item_i,
  output logic  in_ready_o,
  output logic  out_valid_o,
  output item_t out_item_o,
  input  logic  out_pop_i
);

  localparam int Stages = FractionDigits + 1;

  item_t stg_q [Stages];
  logic  vld_q [Stages];
  item_t nxt   [Stages];
  logic  nxt_v [Stages];
  logic  rdy   [Stages];

  // Ready ripples back from the result register
  always_comb begin
    rdy[Stages-1] = !vld_q[Stages-1] || out_pop_i;
    for (int i = Stages - 2; i >= 0; i--) begin
      rdy[i] = !vld_q[i] || rdy[i+1];
    end
  end

  assign nxt[0]   = in_item_i;
  assign nxt_v[0] = in_valid_i;

  // One padding step between neighbouring stages
  for (genvar g = 1; g < Stages; g++) begin : g_step
    mul_res_t m;
    assign m = mul10_add(stg_q[g-1].value, '0);
    always_comb begin
      nxt[g]   = stg_q[g-1];
      nxt_v[g] = vld_q[g-1];
      if (stg_q[g-1].pad != '0) begin
        nxt[g].value = m.value;
        nxt[g].ovf   = stg_q[g-1].ovf | m.ovf;
        nxt[g].pad   = stg_q[g-1].pad - 1'b1;
      end
    end
  end

  // Advance the stages
  for (genvar g = 0; g < Stages; g++) begin : g_stage
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g] <= 1'b0;
      end else if (rdy[g]) begin
        vld_q[g] <= nxt_v[g];
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[g] && nxt_v[g]) begin
        stg_q[g] <= nxt[g];
      end
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = vld_q[Stages-1];
  assign out_item_o  = stg_q[Stages-1];

endmodule

// ===== rtl/decimal_text_to_fixed_point.sv =====
// ----------------------------------------------------------------------------
// decimal_text_to_fixed_point
// Streaming ASCII decimal parser: one character per transaction, one fixed
// point result per ended field.
// ----------------------------------------------------------------------------
// Throughput: one character per cycle while the scaling stages accept, set by the
//   times-ten-add step in the back end and one padding step between scaling stages.
// Path: the closing character is stored in the queue, closed by the back end into
//   the first scaling stage, then padded stage by stage up to the result register
//   on the ports.
// Reset: asynchronous, active low; clears the queue, field state, sticky
//   error bits and all stage valids. No clearing pass.
module decimal_text_to_fixed_point import dttf_pkg::*; #(
  parameter int FRACTION_DIGITS = FRACTION_DIGITS_DEF,
  parameter int QUEUE_DEPTH     = QUEUE_DEPTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic [CHAR_W-1:0]  ch_i,
  output logic               empty,
  input  logic               pop,
  output logic [VALUE_W-1:0] value_o,
  output logic               found_o,
  output logic               bad_char_o,
  output logic               minus_seen_o,
  output logic               overflow_o,
  output logic [ERR_W-1:0]   sticky_errors_o
);

  logic  q_wr, q_valid, q_rd;
  tok_t  wr_tok, rd_tok;
  logic  res_valid, res_ready, out_valid;
  item_t res_item, out_item;

  // Front end
  dttf_class u_class (
    .push_i   (push),
    .q_full_i (full),
    .ch_i     (ch_i),
    .q_wr_o   (q_wr),
    .tok_o    (wr_tok)
  );

  dttf_queue #(
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (q_wr),
    .wr_tok_i (wr_tok),
    .full_o   (full),
    .rd_i     (q_rd),
    .valid_o  (q_valid),
    .rd_tok_o (rd_tok)
  );

  // Back end
  dttf_accum #(
    .FractionDigits (FRACTION_DIGITS)
  ) u_accum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tok_valid_i (q_valid),
    .tok_i       (rd_tok),
    .tok_pop_o   (q_rd),
    .res_ready_i (res_ready),
    .res_valid_o (res_valid),
    .res_o       (res_item)
  );

  dttf_scale #(
    .FractionDigits (FRACTION_DIGITS)
  ) u_scale (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (res_valid),
    .in_item_i   (res_item),
    .in_ready_o  (res_ready),
    .out_valid_o (out_valid),
    .out_item_o  (out_item),
    .out_pop_i   (pop)
  );

  // Drive the result ports
  assign empty           = !out_valid;
  assign value_o         = out_item.value;
  assign found_o         = out_item.found;
  assign bad_char_o      = out_item.bad;
  assign minus_seen_o    = out_item.minus;
  assign overflow_o      = out_item.ovf;
  assign sticky_errors_o = out_item.sticky;

  // A field without digits gives zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !found_o) |-> (value_o == '0))
    else $error("result without digits carries a non-zero value");

  // Saturation always pins the value at the maximum
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && overflow_o) |-> (value_o == VALUE_MAX))
    else $error("overflow flagged but value not saturated");

  // A leading minus is itself a bad character, and both reach the sticky bits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && minus_seen_o) |-> (bad_char_o && sticky_errors_o == '1))
    else $error("minus flag without bad character or sticky bits");

  // The back end only consumes tokens that the queue holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_rd |-> q_valid)
    else $error("token popped from an empty queue");

endmodule

// ===== tb/decimal_text_to_fixed_point_test.sv =====
// ----------------------------------------------------------------------------
// decimal_text_to_fixed_point_test
// Self-checking bench for the streaming decimal text parser. Characters go in
// through the push side with random gaps. A scoreboard mirrors the field
// parsing and scaling and keeps the expected fixed point results in order.
// Each popped result is compared field by field against the oldest one.
// ----------------------------------------------------------------------------
module decimal_text_to_fixed_point_test import dttf_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          FRAC_DIGITS = FRACTION_DIGITS_DEF;
  localparam int          RANDOM_CHARS = 1200;
  localparam int unsigned CYCLE_LIMIT = 100000;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               found;
    logic               bad_char;
    logic               minus_seen;
    logic               overflow;
    logic [ERR_W-1:0]   sticky;
  } field_result_t;

  // Mirror of the parser plus the queue of results still to come out
  class fixed_point_scoreboard;
    field_result_t     pending[$];
    int unsigned       mismatches;
    longint unsigned   magnitude;
    bit                in_field;
    bit                digit_seen;
    bit                point_seen;
    bit                first_minus;
    int unsigned       frac_count;
    int unsigned       char_pos;
    logic [FLAG_W-1:0] field_flags;
    logic [ERR_W-1:0]  error_bits;

    function new();
      mismatches = 0;
      error_bits = '0;
      clear_field();
    endfunction

    function void clear_field();
      magnitude   = 0;
      in_field    = 1'b0;
      digit_seen  = 1'b0;
      point_seen  = 1'b0;
      first_minus = 1'b0;
      frac_count  = 0;
      char_pos    = 0;
      field_flags = '0;
    endfunction

    function bit is_blank(logic [CHAR_W-1:0] c);
      return c == ASCII_BLANK || c == ASCII_TAB;
    endfunction

    // Multiply by ten and add, saturating at the field maximum
    function longint unsigned times_ten_plus(longint unsigned x, int unsigned d);
      longint unsigned r;
      r = x * 10 + d;
      if (r > VALUE_MAX) begin
        field_flags[FLAG_OVF] = 1'b1;
        return VALUE_MAX;
      end
      return r;
    endfunction

    // Pad the fraction out and queue the finished field
    function void close_field();
      field_result_t   res;
      longint unsigned v;
      v = 0;
      if (digit_seen) begin
        v = magnitude;
        for (int k = frac_count; k < FRAC_DIGITS; k++) v = times_ten_plus(v, 0);
      end
      error_bits[0] = error_bits[0] | field_flags[FLAG_BAD];
      error_bits[1] = error_bits[1] | field_flags[FLAG_MINUS];
      res.value      = v[VALUE_W-1:0];
      res.found      = digit_seen;
      res.bad_char   = field_flags[FLAG_BAD];
      res.minus_seen = field_flags[FLAG_MINUS];
      res.overflow   = field_flags[FLAG_OVF];
      res.sticky     = error_bits;
      pending = {pending, res};
      clear_field();
    endfunction

    // Advance the mirror by one accepted character
    function void note_char(logic [CHAR_W-1:0] c);
      if (!in_field) begin
        if (is_blank(c)) return;
        if (c == ASCII_NUL) begin
          close_field();
          return;
        end
        in_field = 1'b1;
      end else if (is_blank(c) || c == ASCII_NUL) begin
        close_field();
        return;
      end

      if (c >= ASCII_ZERO && c <= ASCII_NINE) begin
        if (char_pos == 1 && first_minus) field_flags[FLAG_MINUS] = 1'b1;
        digit_seen = 1'b1;
        if (!point_seen) begin
          magnitude = times_ten_plus(magnitude, c - ASCII_ZERO);
        end else if (frac_count < FRAC_DIGITS) begin
          magnitude  = times_ten_plus(magnitude, c - ASCII_ZERO);
          frac_count = frac_count + 1;
        end
      end else if (c == ASCII_POINT && !point_seen) begin
        point_seen = 1'b1;
      end else begin
        if (char_pos == 0 && c == ASCII_MINUS) first_minus = 1'b1;
        field_flags[FLAG_BAD] = 1'b1;
      end

      if (char_pos < 3) char_pos++;
    endfunction

    function void compare_field(string name, longint unsigned want, longint unsigned got);
      if (want != got) begin
        $error("%s: expected %0d, actual %0d", name, want, got);
        mismatches++;
      end
    endfunction

    // Check one popped transaction against the oldest expectation
    function void check_result(field_result_t got);
      field_result_t want;
      if (pending.size() == 0) begin
        $error("result popped with no field pending: value %0d", got.value);
        mismatches++;
        return;
      end
      want = pending.pop_front();
      compare_field("value", want.value, got.value);
      compare_field("found", want.found, got.found);
      compare_field("bad_char", want.bad_char, got.bad_char);
      compare_field("minus_seen", want.minus_seen, got.minus_seen);
      compare_field("overflow", want.overflow, got.overflow);
      compare_field("sticky_errors", want.sticky, got.sticky);
    endfunction
  endclass

  logic               clk_i  = 1'b0;
  logic               rst_ni = 1'b0;
  logic               push   = 1'b0;
  logic               full;
  logic [CHAR_W-1:0]  ch_i   = '0;
  logic               empty;
  logic               pop    = 1'b0;
  logic [VALUE_W-1:0] value_o;
  logic               found_o;
  logic               bad_char_o;
  logic               minus_seen_o;
  logic               overflow_o;
  logic [ERR_W-1:0]   sticky_errors_o;

  fixed_point_scoreboard sb = new();
  int unsigned           chars_sent = 0;
  int unsigned           cycles = 0;

  decimal_text_to_fixed_point u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .ch_i           (ch_i),
    .empty          (empty),
    .pop            (pop),
    .value_o        (value_o),
    .found_o        (found_o),
    .bad_char_o     (bad_char_o),
    .minus_seen_o   (minus_seen_o),
    .overflow_o     (overflow_o),
    .sticky_errors_o(sticky_errors_o)
  );

  always #10 clk_i = ~clk_i;

  // Watchdog on the whole run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("decimal_text_to_fixed_point regression: fail");
      $finish;
    end
  end

  // Pop side: check each transaction, stall at random outside the quiet window
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pop && !empty) begin
        sb.check_result('{value_o, found_o, bad_char_o, minus_seen_o, overflow_o,
                          sticky_errors_o});
      end
      if (cycles >= 600 && cycles < 1000) begin
        pop <= 1'b1;
      end else begin
        pop <= $urandom_range(0, 99) >= 17;
      end
    end
  end

  // Offer one character and hold it until the push transaction completes
  task automatic send_char(logic [CHAR_W-1:0] c);
    bit quiet;
    quiet = chars_sent >= 400 && chars_sent < 650;
    while (!quiet && $urandom_range(0, 99) < 17) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    ch_i <= c;
    do @(posedge clk_i); while (full);
    sb.note_char(c);
    chars_sent++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  function automatic logic [CHAR_W-1:0] pick_separator();
    case ($urandom_range(0, 2))
      0:       return ASCII_BLANK;
      1:       return ASCII_TAB;
      default: return ASCII_NUL;
    endcase
  endfunction

  task automatic send_digits(int unsigned n);
    for (int i = 0; i < n; i++) send_char(CHAR_W'(ASCII_ZERO + $urandom_range(0, 9)));
  endtask

  // Mostly well-formed numbers, some long enough to saturate, the rest noise
  task automatic send_random_field();
    int unsigned n;
    n = $urandom_range(0, 2);
    for (int i = 0; i < n; i++) send_char($urandom_range(0, 1) ? ASCII_BLANK : ASCII_TAB);
    if ($urandom_range(0, 99) < 80) begin
      if ($urandom_range(0, 9) == 0) send_char(ASCII_MINUS);
      send_digits(($urandom_range(0, 9) == 0) ? $urandom_range(12, 18) : $urandom_range(0, 6));
      if ($urandom_range(0, 1)) begin
        send_char(ASCII_POINT);
        send_digits($urandom_range(0, 6));
      end
    end else begin
      n = $urandom_range(0, 4);
      for (int i = 0; i < n; i++) send_char(CHAR_W'($urandom_range(0, 255)));
    end
    send_char(pick_separator());
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed opening: empty field, skipped blanks, minus, second point,
    // lone minus, excess fraction digits and high characters
    send_char(ASCII_NUL);
    send_text(" \t-5\t");
    send_text("1..2 ");
    send_text("-. ");
    send_text("9.12345");
    send_char(ASCII_NUL);
    send_char(8'h80);
    send_char(8'hFF);
    send_char(ASCII_BLANK);

    while (chars_sent < RANDOM_CHARS + 25) send_random_field();
    push <= 1'b0;

    // Drain, then give the pipeline time to show any stray result
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (2 * (FRAC_DIGITS + 2) + 8) @(posedge clk_i);

    if (sb.mismatches == 0) begin
      $display("decimal_text_to_fixed_point regression: pass");
    end else begin
      $display("decimal_text_to_fixed_point regression: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/dttf_pkg.sv
rtl/dttf_class.sv
rtl/dttf_queue.sv
rtl/dttf_accum.sv
rtl/dttf_scale.sv
rtl/decimal_text_to_fixed_point.sv
tb/decimal_text_to_fixed_point_test.sv
